/* rtl/dtsf_pkg.sv */
// shared types, constants and helpers for the decimal text to single float converter
// no dependencies; imported by every module of the block
package dtsf_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       new_string;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [11:0] consumed_count;
    logic        converted;
  } out_item_t;

  localparam int CntW             = 12;
  localparam int CntMax           = 2**CntW - 1;
  localparam int MaxLengthDefault = 4095;

  // single precision constants
  localparam logic [31:0] F_ZERO  = 32'h0000_0000;
  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_TEN   = 32'h4120_0000;
  localparam logic [31:0] F_TENTH = 32'h3DCC_CCCD;
  localparam logic [31:0] F_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] F_INF   = 32'h7F80_0000;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LE    = 8'h65;

  // float unit operations
  localparam logic [1:0] FOP_MUL = 2'd0;
  localparam logic [1:0] FOP_ADD = 2'd1;
  localparam logic [1:0] FOP_DIV = 2'd2;

  // datapath arithmetic steps
  localparam logic [3:0] OP_INT_MUL  = 4'd0;
  localparam logic [3:0] OP_INT_ADD  = 4'd1;
  localparam logic [3:0] OP_FR_MUL   = 4'd2;
  localparam logic [3:0] OP_FR_ADD   = 4'd3;
  localparam logic [3:0] OP_FAC_MUL  = 4'd4;
  localparam logic [3:0] OP_SC_MUL   = 4'd5;
  localparam logic [3:0] OP_BASE_MUL = 4'd6;
  localparam logic [3:0] OP_FIN_MUL  = 4'd7;
  localparam logic [3:0] OP_FIN_DIV  = 4'd8;

  // result kinds
  localparam logic [1:0] EM_FAIL  = 2'd0;
  localparam logic [1:0] EM_ACC   = 2'd1;
  localparam logic [1:0] EM_ACC_E = 2'd2;
  localparam logic [1:0] EM_TMP   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       bump;
    logic       set_neg;
    logic       set_eneg;
    logic       exp_dig;
    logic       mark_exp;
    logic       set_dseen;
    logic       fstart;
    logic [3:0] fop;
    logic       sc_init;
    logic       sc_shift;
    logic       emit;
    logic [1:0] ekind;
  } dp_cmd_t;

  typedef struct packed {
    logic fresh;
    logic is_digit;
    logic is_space;
    logic is_plus;
    logic is_minus;
    logic is_dot;
    logic is_emark;
    logic dseen;
    logic eneg;
    logic fdone;
    logic e_zero;
    logic e_lsb;
    logic e_last;
    logic out_full;
  } dp_stat_t;

  function automatic logic [31:0] digit_float(input logic [3:0] d);
    logic [31:0] f;
    case (d)
      4'd1:    f = 32'h3F80_0000;
      4'd2:    f = 32'h4000_0000;
      4'd3:    f = 32'h4040_0000;
      4'd4:    f = 32'h4080_0000;
      4'd5:    f = 32'h40A0_0000;
      4'd6:    f = 32'h40C0_0000;
      4'd7:    f = 32'h40E0_0000;
      4'd8:    f = 32'h4100_0000;
      4'd9:    f = 32'h4110_0000;
      default: f = F_ZERO;
    endcase
    return f;
  endfunction

endpackage

/* rtl/dtsf_fpu.sv */
// multi-cycle single precision unit: multiply, add of non-negative values, divide
// round to nearest even, subnormals handled; uses dtsf_pkg
module dtsf_fpu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);
  import dtsf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UNP  = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PACK = 3'd4;

  typedef struct packed {
    logic signed [11:0] e;
    logic [23:0]        m;
  } unp_t;

  logic [2:0]         st;
  logic [1:0]         op_r;
  logic [31:0]        a_r, b_r;
  logic signed [11:0] ea, eb, e_r;
  logic [23:0]        ma, mb;
  logic               spec;
  logic [30:0]        spec_val;
  logic [47:0]        sig_r;
  logic [25:0]        rem;
  logic [25:0]        q;
  logic [4:0]         dcnt;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] lz;
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  function automatic unp_t unpack(input logic [30:0] x);
    unp_t       u;
    logic [23:0] m24;
    logic [4:0]  lz;
    m24 = {1'b0, x[22:0]};
    lz  = lzc24(m24);
    if (x[30:23] != 8'd0) begin
      u.m = {1'b1, x[22:0]};
      u.e = $signed({4'd0, x[30:23]}) - 12'sd127;
    end else begin
      u.m = m24 << lz;
      u.e = -12'sd126 - $signed({7'd0, lz});
    end
    return u;
  endfunction

  // value = sig / 2^47 * 2^e
  function automatic logic [30:0] pack(input logic signed [11:0] e, input logic [47:0] sig);
    logic signed [11:0] be;
    logic [11:0]        shl;
    logic [5:0]         sh;
    logic [47:0]        sft;
    logic               lost, g, s, l;
    logic [30:0]        comb;
    be   = e + 12'sd127;
    shl  = 12'(12'sd1 - be);
    sh   = (shl > 12'd48) ? 6'd48 : shl[5:0];
    sft  = sig >> sh;
    lost = (sft << sh) != sig;
    if (be >= 12'sd1) begin
      comb = {be[7:0], sig[46:24]};
      g    = sig[23];
      s    = |sig[22:0];
      l    = sig[24];
    end else begin
      comb = {8'd0, sft[46:24]};
      g    = sft[23];
      s    = (|sft[22:0]) | lost;
      l    = sft[24];
    end
    if (be > 12'sd254) return F_INF[30:0];
    return comb + 31'(g & (s | l));
  endfunction

  logic a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
  unp_t ua, ub;

  assign a_zero = a_r[30:0] == 31'd0;
  assign b_zero = b_r[30:0] == 31'd0;
  assign a_inf  = (a_r[30:23] == 8'hFF) && (a_r[22:0] == 23'd0);
  assign b_inf  = (b_r[30:23] == 8'hFF) && (b_r[22:0] == 23'd0);
  assign a_nan  = (a_r[30:23] == 8'hFF) && (a_r[22:0] != 23'd0);
  assign b_nan  = (b_r[30:23] == 8'hFF) && (b_r[22:0] != 23'd0);
  assign ua     = unpack(a_r[30:0]);
  assign ub     = unpack(b_r[30:0]);

  // add path, operands known non-negative
  logic        a_big;
  logic [30:0] big, sml;
  logic [8:0]  eb_big, eb_sml;
  logic [8:0]  diff;
  logic [5:0]  ash;
  logic [49:0] sml_full, sml_sft;
  logic        alost;
  logic [50:0] asum;

  always_comb begin
    a_big    = a_r[30:0] >= b_r[30:0];
    big      = a_big ? a_r[30:0] : b_r[30:0];
    sml      = a_big ? b_r[30:0] : a_r[30:0];
    eb_big   = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    eb_sml   = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
    diff     = eb_big - eb_sml;
    ash      = (diff > 9'd50) ? 6'd50 : diff[5:0];
    sml_full = {sml[30:23] != 8'd0, sml[22:0], 26'd0};
    sml_sft  = sml_full >> ash;
    alost    = (sml_sft << ash) != sml_full;
    asum     = {1'b0, big[30:23] != 8'd0, big[22:0], 26'd0} + {1'b0, sml_sft};
  end

  logic [47:0] prod;
  logic        ge;
  logic [25:0] rem_n;
  logic [25:0] qn;

  assign prod  = ma * mb;
  assign ge    = rem >= {2'd0, mb};
  assign rem_n = ge ? rem - {2'd0, mb} : rem;
  assign qn    = {q[24:0], ge};

  assign done = st == S_PACK;
  assign res  = {1'b0, spec ? spec_val : pack(e_r, sig_r)};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE, S_PACK: begin
          if (start) begin
            a_r  <= a;
            b_r  <= b;
            op_r <= op;
            st   <= S_UNP;
          end else begin
            st <= S_IDLE;
          end
        end
        S_UNP: begin
          ea   <= ua.e;
          ma   <= ua.m;
          eb   <= ub.e;
          mb   <= ub.m;
          spec <= 1'b0;
          case (op_r)
            FOP_MUL: begin
              if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                spec <= 1'b1; spec_val <= F_QNAN[30:0];
              end else if (a_inf || b_inf) begin
                spec <= 1'b1; spec_val <= F_INF[30:0];
              end else if (a_zero || b_zero) begin
                spec <= 1'b1; spec_val <= F_ZERO[30:0];
              end
            end
            FOP_DIV: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                spec <= 1'b1; spec_val <= F_QNAN[30:0];
              end else if (a_inf || b_zero) begin
                spec <= 1'b1; spec_val <= F_INF[30:0];
              end else if (a_zero || b_inf) begin
                spec <= 1'b1; spec_val <= F_ZERO[30:0];
              end
            end
            FOP_ADD: begin
              if (a_nan || b_nan) begin
                spec <= 1'b1; spec_val <= F_QNAN[30:0];
              end else if (a_inf || b_inf) begin
                spec <= 1'b1; spec_val <= F_INF[30:0];
              end else if (a_r[30:23] == 8'd0 && b_r[30:23] == 8'd0) begin
                // two subnormals add exactly on the raw encodings
                spec <= 1'b1; spec_val <= a_r[30:0] + b_r[30:0];
              end
            end
            default: spec <= 1'b0;
          endcase
          st <= S_CALC;
        end
        S_CALC: begin
          st <= S_PACK;
          case (op_r)
            FOP_MUL: begin
              if (prod[47]) begin
                sig_r <= prod;
                e_r   <= ea + eb + 12'sd1;
              end else begin
                sig_r <= {prod[46:0], 1'b0};
                e_r   <= ea + eb;
              end
            end
            FOP_ADD: begin
              if (asum[50]) begin
                sig_r <= {asum[50:4], asum[3] | (|asum[2:0]) | alost};
                e_r   <= $signed({3'd0, eb_big}) - 12'sd126;
              end else begin
                sig_r <= {asum[49:3], asum[2] | (|asum[1:0]) | alost};
                e_r   <= $signed({3'd0, eb_big}) - 12'sd127;
              end
            end
            FOP_DIV: begin
              rem  <= {2'd0, ma};
              q    <= '0;
              dcnt <= '0;
              e_r  <= ea - eb;
              if (!spec) st <= S_DIV;
            end
            default: sig_r <= '0;
          endcase
        end
        S_DIV: begin
          // one quotient bit a cycle, restoring
          q    <= qn;
          rem  <= {rem_n[24:0], 1'b0};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd25) begin
            st <= S_PACK;
            if (qn[25]) begin
              sig_r <= {qn, 21'd0, rem_n != 26'd0};
            end else begin
              sig_r <= {qn[24:0], 22'd0, rem_n != 26'd0};
              e_r   <= e_r - 12'sd1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dtsf_dp.sv */
// datapath: character register, parse registers, counters, result register
// holds the float unit; uses dtsf_pkg and dtsf_fpu
module dtsf_dp #(
  parameter int MAX_LENGTH = dtsf_pkg::MaxLengthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  dtsf_pkg::in_item_t  in_data,
  input  dtsf_pkg::dp_cmd_t   cmd,
  output dtsf_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output dtsf_pkg::out_item_t out_data
);
  import dtsf_pkg::*;

  localparam int          LimInt = (MAX_LENGTH < CntMax) ? MAX_LENGTH : CntMax;
  localparam logic [11:0] CntLim = 12'(LimInt);

  localparam logic [2:0] D_ACC   = 3'd0;
  localparam logic [2:0] D_TMP   = 3'd1;
  localparam logic [2:0] D_FAC   = 3'd2;
  localparam logic [2:0] D_SCALE = 3'd3;
  localparam logic [2:0] D_BASE  = 3'd4;

  logic [7:0]  chr;
  logic        fresh, neg, eneg, dseen;
  logic [31:0] acc, fac, tmp, scale, base;
  logic [15:0] expv, ebits;
  logic [11:0] cnt, cnt_e;
  logic [3:0]  fop_r;

  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] dig_f;
  logic [19:0] emul;
  logic [15:0] expv_next;
  logic        fdone;
  logic [31:0] fres, tmp_f;
  logic [1:0]  f_op;
  logic [31:0] f_a, f_b;
  logic [2:0]  dest;

  assign is_digit  = chr >= CH_ZERO && chr <= CH_NINE;
  assign digit     = 4'(chr - CH_ZERO);
  assign dig_f     = digit_float(digit);
  assign emul      = ({4'd0, expv} << 3) + ({4'd0, expv} << 1) + {16'd0, digit};
  assign expv_next = (emul > 20'd65535) ? 16'hFFFF : emul[15:0];

  always_comb begin
    case (fop_r)
      OP_INT_ADD, OP_FR_ADD:    dest = D_ACC;
      OP_FAC_MUL:               dest = D_FAC;
      OP_SC_MUL:                dest = D_SCALE;
      OP_BASE_MUL:              dest = D_BASE;
      default:                  dest = D_TMP;
    endcase
  end

  // a step started as the previous one finishes sees its product at once
  assign tmp_f = (fdone && dest == D_TMP) ? fres : tmp;

  always_comb begin
    case (cmd.fop)
      OP_INT_MUL:  begin f_op = FOP_MUL; f_a = acc;   f_b = F_TEN;   end
      OP_INT_ADD:  begin f_op = FOP_ADD; f_a = tmp_f; f_b = dig_f;   end
      OP_FR_MUL:   begin f_op = FOP_MUL; f_a = dig_f; f_b = fac;     end
      OP_FR_ADD:   begin f_op = FOP_ADD; f_a = acc;   f_b = tmp_f;   end
      OP_FAC_MUL:  begin f_op = FOP_MUL; f_a = fac;   f_b = F_TENTH; end
      OP_SC_MUL:   begin f_op = FOP_MUL; f_a = scale; f_b = base;    end
      OP_BASE_MUL: begin f_op = FOP_MUL; f_a = base;  f_b = base;    end
      OP_FIN_DIV:  begin f_op = FOP_DIV; f_a = acc;   f_b = scale;   end
      default:     begin f_op = FOP_MUL; f_a = acc;   f_b = scale;   end
    endcase
  end

  dtsf_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fstart),
    .op    (f_op),
    .a     (f_a),
    .b     (f_b),
    .done  (fdone),
    .res   (fres)
  );

  logic [31:0] fin_src, fin_bits;
  assign fin_src  = (cmd.ekind == EM_TMP) ? tmp : acc;
  assign fin_bits = (((fin_src[30:23] == 8'hFF) && (fin_src[22:0] != 23'd0)) ? F_QNAN : fin_src)
                    ^ {neg, 31'd0};

  always_comb begin
    stat.fresh    = fresh;
    stat.is_digit = is_digit;
    stat.is_space = chr == CH_SPACE;
    stat.is_plus  = chr == CH_PLUS;
    stat.is_minus = chr == CH_MINUS;
    stat.is_dot   = chr == CH_DOT;
    stat.is_emark = chr == CH_LE || chr == CH_UE;
    stat.dseen    = dseen;
    stat.eneg     = eneg;
    stat.fdone    = fdone;
    stat.e_zero   = ebits == 16'd0;
    stat.e_lsb    = ebits[0];
    stat.e_last   = ebits[15:1] == 15'd0;
    stat.out_full = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b0;
      neg       <= 1'b0;
      eneg      <= 1'b0;
      dseen     <= 1'b0;
      acc       <= F_ZERO;
      fac       <= F_TENTH;
      expv      <= '0;
      cnt       <= '0;
      cnt_e     <= '0;
      ebits     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        chr   <= in_data.text_char;
        fresh <= in_data.new_string;
      end
      if (cmd.clr) begin
        fresh <= 1'b0;
        neg   <= 1'b0;
        eneg  <= 1'b0;
        dseen <= 1'b0;
        acc   <= F_ZERO;
        fac   <= F_TENTH;
        expv  <= '0;
        cnt   <= '0;
        cnt_e <= '0;
      end else begin
        if (cmd.bump && cnt < CntLim) cnt <= cnt + 12'd1;
        if (cmd.mark_exp) cnt_e <= cnt;
        if (cmd.set_neg) neg <= 1'b1;
        if (cmd.set_eneg) eneg <= 1'b1;
        if (cmd.set_dseen) dseen <= 1'b1;
        if (cmd.exp_dig) expv <= expv_next;
        if (fdone && dest == D_ACC) acc <= fres;
        if (fdone && dest == D_FAC) fac <= fres;
      end
      if (cmd.fstart) fop_r <= cmd.fop;
      if (fdone && dest == D_TMP) tmp <= fres;
      if (cmd.sc_init) begin
        scale <= F_ONE;
        base  <= F_TEN;
        ebits <= expv;
      end else begin
        if (fdone && dest == D_SCALE) scale <= fres;
        if (fdone && dest == D_BASE) base <= fres;
        if (cmd.sc_shift) ebits <= {1'b0, ebits[15:1]};
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (cmd.ekind == EM_FAIL) begin
          out_data <= '0;
        end else begin
          out_data.value_bits     <= fin_bits;
          out_data.consumed_count <= (cmd.ekind == EM_ACC_E) ? cnt_e : cnt;
          out_data.converted      <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/dtsf_ctrl.sv */
// controller: parse phase and sequencing of the float steps for each character
// drives dtsf_dp through dp_cmd_t and reads dp_stat_t; uses dtsf_pkg
module dtsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output dtsf_pkg::dp_cmd_t  cmd,
  input  dtsf_pkg::dp_stat_t stat
);
  import dtsf_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_INT_MUL  = 4'd2;
  localparam logic [3:0] S_INT_ADD  = 4'd3;
  localparam logic [3:0] S_FR_MUL   = 4'd4;
  localparam logic [3:0] S_FR_ADD   = 4'd5;
  localparam logic [3:0] S_FAC_MUL  = 4'd6;
  localparam logic [3:0] S_SC_CHK   = 4'd7;
  localparam logic [3:0] S_SC_MUL   = 4'd8;
  localparam logic [3:0] S_BASE_MUL = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LEAD  = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_FRAC  = 3'd3;
  localparam logic [2:0] PH_EMARK = 3'd4;
  localparam logic [2:0] PH_ESIGN = 3'd5;
  localparam logic [2:0] PH_EDIG  = 3'd6;

  logic [3:0] st, st_next;
  logic [2:0] ph, ph_next;
  logic [1:0] ekind, ekind_next;
  logic       in_frac;

  assign in_ready = st == S_IDLE;
  assign in_frac  = ph == PH_FRAC;

  always_comb begin
    cmd        = '0;
    cmd.ekind  = ekind;
    st_next    = st;
    ph_next    = ph;
    ekind_next = ekind;
    case (st)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_next  = S_DEC;
        end
      end
      S_DEC: begin
        st_next = S_IDLE;
        if (stat.fresh) begin
          cmd.clr = 1'b1;
          ph_next = PH_LEAD;
          st_next = S_DEC;
        end else if (ph == PH_LEAD && (stat.is_space || stat.is_plus || stat.is_minus)) begin
          cmd.bump    = 1'b1;
          cmd.set_neg = stat.is_minus;
          if (!stat.is_space) ph_next = PH_INT;
        end else if (ph == PH_LEAD || ph == PH_INT || ph == PH_FRAC) begin
          // first other character after the lead falls into the integer part
          if (stat.is_digit) begin
            ph_next    = in_frac ? PH_FRAC : PH_INT;
            cmd.fstart = 1'b1;
            cmd.fop    = in_frac ? OP_FR_MUL : OP_INT_MUL;
            st_next    = in_frac ? S_FR_MUL : S_INT_MUL;
          end else if (stat.is_dot && !in_frac) begin
            cmd.bump = 1'b1;
            ph_next  = PH_FRAC;
          end else if (!stat.dseen) begin
            ekind_next = EM_FAIL;
            st_next    = S_EMIT;
          end else if (stat.is_emark) begin
            cmd.mark_exp = 1'b1;
            cmd.bump     = 1'b1;
            ph_next      = PH_EMARK;
          end else begin
            ekind_next = EM_ACC;
            st_next    = S_EMIT;
          end
        end else if (ph == PH_EMARK || ph == PH_ESIGN) begin
          if (ph == PH_EMARK && (stat.is_plus || stat.is_minus)) begin
            cmd.bump     = 1'b1;
            cmd.set_eneg = stat.is_minus;
            ph_next      = PH_ESIGN;
          end else if (stat.is_digit) begin
            cmd.exp_dig = 1'b1;
            cmd.bump    = 1'b1;
            ph_next     = PH_EDIG;
          end else begin
            ekind_next = EM_ACC_E;
            st_next    = S_EMIT;
          end
        end else if (ph == PH_EDIG) begin
          if (stat.is_digit) begin
            cmd.exp_dig = 1'b1;
            cmd.bump    = 1'b1;
          end else begin
            cmd.sc_init = 1'b1;
            st_next     = S_SC_CHK;
          end
        end
      end
      S_INT_MUL: begin
        if (stat.fdone) begin
          cmd.fstart = 1'b1;
          cmd.fop    = OP_INT_ADD;
          st_next    = S_INT_ADD;
        end
      end
      S_FR_MUL: begin
        if (stat.fdone) begin
          cmd.fstart = 1'b1;
          cmd.fop    = OP_FR_ADD;
          st_next    = S_FR_ADD;
        end
      end
      S_FR_ADD: begin
        if (stat.fdone) begin
          cmd.fstart = 1'b1;
          cmd.fop    = OP_FAC_MUL;
          st_next    = S_FAC_MUL;
        end
      end
      S_INT_ADD, S_FAC_MUL: begin
        if (stat.fdone) begin
          cmd.set_dseen = 1'b1;
          cmd.bump      = 1'b1;
          st_next       = S_IDLE;
        end
      end
      S_SC_CHK: begin
        // square and multiply, lowest exponent bit first
        cmd.fstart = 1'b1;
        if (stat.e_zero) begin
          cmd.fop = stat.eneg ? OP_FIN_DIV : OP_FIN_MUL;
          st_next = S_FIN;
        end else if (stat.e_lsb) begin
          cmd.fop = OP_SC_MUL;
          st_next = S_SC_MUL;
        end else begin
          cmd.fop = OP_BASE_MUL;
          st_next = S_BASE_MUL;
        end
      end
      S_SC_MUL: begin
        if (stat.fdone) begin
          if (stat.e_last) begin
            cmd.sc_shift = 1'b1;
            st_next      = S_SC_CHK;
          end else begin
            cmd.fstart = 1'b1;
            cmd.fop    = OP_BASE_MUL;
            st_next    = S_BASE_MUL;
          end
        end
      end
      S_BASE_MUL: begin
        if (stat.fdone) begin
          cmd.sc_shift = 1'b1;
          st_next      = S_SC_CHK;
        end
      end
      S_FIN: begin
        if (stat.fdone) begin
          ekind_next = EM_TMP;
          st_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit = 1'b1;
          ph_next  = PH_IDLE;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      ph    <= PH_IDLE;
      ekind <= EM_FAIL;
    end else begin
      st    <= st_next;
      ph    <= ph_next;
      ekind <= ekind_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_full)
    else $error("result written while output beat still held");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> ph == PH_IDLE && st == S_IDLE)
    else $error("parse phase not closed after result");
  a_fresh_lead: assert property (@(posedge clk) disable iff (rst)
    (st == S_DEC && stat.fresh) |=> ph == PH_LEAD && st == S_DEC)
    else $error("new string did not restart the parse");
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.fstart && st != S_DEC && st != S_SC_CHK) |-> stat.fdone)
    else $error("float step started while unit busy");
`endif

endmodule

/* rtl/decimal_text_to_single_float.sv */
// decimal text to single precision float converter, top level
// instantiates dtsf_ctrl and dtsf_dp; uses dtsf_pkg
//
// Usage: the in channel takes one character per beat with new_string set on
// the first character of each string; the character that ends a string gives
// one result beat on the out channel (value bits, consumed count, converted).
// Characters before the first string, or after a string has ended without a
// new_string mark, are dropped without a result.
// Timing: each beat is registered when taken and decoded in the next cycle; a beat
// with new_string is decoded once more after the clear. An integer digit runs a
// multiply then an add on the shared float unit, a fraction digit three float
// steps (multiply, add, factor update). The ending character of a string with an
// exponent adds up to 16 rounds of square and multiply plus a final multiply
// or a divide; no new character is taken until these steps are through.
// The next character is taken while a finished result still waits; when the
// receiver stalls and a second result is due, the block holds in_ready low
// until the first one is taken. Reset returns to idle with no string open.
module decimal_text_to_single_float #(
  parameter int MAX_LENGTH = dtsf_pkg::MaxLengthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtsf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dtsf_pkg::out_item_t out_data
);
  import dtsf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dtsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dtsf_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
